// File: rtl/format_sector_id_interleave_defines.svh
// Assertion macros for the sector ID interleave block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FORMAT_SECTOR_ID_INTERLEAVE_DEFINES_SVH
`define FORMAT_SECTOR_ID_INTERLEAVE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define FSI_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("fsi assertion failed");
// Next-cycle implication, checked out of reset.
`define FSI_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("fsi assertion failed");
`else
`define FSI_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define FSI_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// File: rtl/fsi_pkg.sv
// Shared types and constants for the sector ID interleave block.
// No dependencies; compiled before all other sources.
package fsi_pkg;

  localparam logic [5:0] SPT_A         = 6'd18;
  localparam logic [5:0] SPT_B         = 6'd21;
  localparam logic [1:0] SIZE_CODE_512 = 2'd2;
  localparam logic [1:0] SIZE_CODE_NONE = 2'd0;
  localparam logic [6:0] HEAD_SKEW     = 7'd2;

  // Current slot handed from the sequencer to the ID calculation.
  typedef struct packed {
    logic [7:0] track;
    logic       head;
    logic [5:0] slot;
    logic       rejected;
    logic       last;
  } slot_t;

  // One sector ID record.
  typedef struct packed {
    logic [7:0] id_track;
    logic       id_head;
    logic [5:0] sector_id;
    logic [1:0] size_code;
    logic       rejected;
    logic       last;
  } rec_t;

  // Sequencer status seen by the output stage.
  typedef struct packed {
    logic busy;
    logic advance;
    logic accept;
  } seq_stat_t;

endpackage

// File: rtl/fsi_in_if.sv
// Input channel of the sector ID interleave block: one (track, head) item.
// No dependencies.
interface fsi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track;
  logic       head;

  modport source (output valid, track, head, input ready);
  modport sink   (input valid, track, head, output ready);
endinterface

// File: rtl/fsi_out_if.sv
// Result channel of the sector ID interleave block: the ID records of each item.
// No dependencies.
interface fsi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] id_track;
  logic       id_head;
  logic [5:0] sector_id;
  logic [1:0] size_code;
  logic       rejected;
  logic       last;

  modport source (output valid, id_track, id_head, sector_id, size_code, rejected, last,
                  input ready);
  modport sink   (input valid, id_track, id_head, sector_id, size_code, rejected, last,
                  output ready);
endinterface

// File: rtl/fsi_seq.sv
// Slot sequencer: holds the accepted (track, head) item and steps the slot count.
// Depends on fsi_pkg.
module fsi_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_track,
  input  logic              in_head,
  input  logic [5:0]        spt,
  input  logic              out_free,
  output fsi_pkg::slot_t    slot,
  output fsi_pkg::seq_stat_t stat
);
  import fsi_pkg::*;

  logic       busy_r, busy_nxt;
  logic [5:0] slot_r, slot_nxt;
  logic [7:0] track_r;
  logic       head_r;
  logic       rej_r;
  logic       advance;
  logic       last_slot;
  logic       accept;

  assign advance   = busy_r && out_free;
  assign last_slot = rej_r || (slot_r == spt - 6'd1);
  // A new item is taken when idle, or as the final record of the previous one moves out.
  assign in_ready  = !busy_r || (advance && last_slot);
  assign accept    = in_valid && in_ready;

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (accept) begin
      busy_nxt = 1'b1;
      slot_nxt = 6'd0;
    end else if (advance && last_slot) begin
      busy_nxt = 1'b0;
    end else if (advance) begin
      slot_nxt = slot_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      track_r <= in_track;
      head_r  <= in_head;
      rej_r   <= !((spt == SPT_A) || (spt == SPT_B));
    end
  end

  assign slot.track    = track_r;
  assign slot.head     = head_r;
  assign slot.slot     = slot_r;
  assign slot.rejected = rej_r;
  assign slot.last     = last_slot;

  assign stat.busy    = busy_r;
  assign stat.advance = advance;
  assign stat.accept  = accept;

endmodule

// File: rtl/fsi_calc.sv
// Sector ID calculation: 1:2 interleave, head skew and track skew for one slot.
// Depends on fsi_pkg.
module fsi_calc (
  input  fsi_pkg::slot_t slot,
  input  logic [5:0]     spt,
  output fsi_pkg::rec_t  rec
);
  import fsi_pkg::*;

  logic [6:0] spt_w;
  logic [6:0] half_up;
  logic [6:0] half_down;
  logic [6:0] base_id;
  logic [6:0] head_id;
  logic [6:0] trk_id;

  always_comb begin
    spt_w     = {1'b0, spt};
    half_up   = (spt_w + 7'd1) >> 1;
    half_down = spt_w >> 1;
    base_id   = {2'b00, slot.slot[5:1]} + 7'd1;
    if (slot.slot[0]) begin
      base_id = base_id + half_up;
    end
    // Each skew wraps around by one track length when it would drop below one.
    head_id = base_id;
    if (slot.head) begin
      if (base_id <= HEAD_SKEW) begin
        head_id = base_id + spt_w - HEAD_SKEW;
      end else begin
        head_id = base_id - HEAD_SKEW;
      end
    end
    trk_id = head_id;
    if (slot.track[0]) begin
      if (head_id <= half_down) begin
        trk_id = head_id + spt_w - half_down;
      end else begin
        trk_id = head_id - half_down;
      end
    end

    rec.id_track = slot.track;
    rec.id_head  = slot.head;
    rec.rejected = slot.rejected;
    rec.last     = slot.last;
    if (slot.rejected) begin
      rec.sector_id = 6'd0;
      rec.size_code = SIZE_CODE_NONE;
    end else begin
      rec.sector_id = trk_id[5:0];
      rec.size_code = SIZE_CODE_512;
    end
  end

endmodule

// File: rtl/format_sector_id_interleave.sv
// Top level of the sector ID interleave block: config register, sequencer,
// ID calculation and result register. Depends on fsi_pkg, fsi_in_if, fsi_out_if,
// fsi_seq, fsi_calc and format_sector_id_interleave_defines.svh.
//
//   channel   direction  handshake        payload
//   in_ch     sink       valid / ready    track[7:0], head
//   out_ch    source     valid / ready    id_track, id_head, sector_id, size_code,
//                                         rejected, last
//   cfg       write      cfg_we           cfg_wdata[5:0] = sectors_per_track
//
// An item yields sectors_per_track records (18 or 21), one per cycle, or a
// single rejected record for any other geometry. The item is held in the
// sequencer's input register, and its first record then passes through the
// result register before it is offered. The next item is accepted in the cycle
// its predecessor's final record is loaded into the result register, so items
// stream without gaps. A stall on the result channel freezes the slot counter.
// Reset is synchronous, active low, and sets sectors_per_track to 18.
`include "format_sector_id_interleave_defines.svh"
module format_sector_id_interleave (
  input  logic       clk,
  input  logic       rst_n,
  fsi_in_if.sink     in_ch,
  fsi_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);
  import fsi_pkg::*;

  logic [5:0] spt_r;
  logic       out_valid_r;
  rec_t       out_rec_r;
  logic       out_free;
  slot_t      slot;
  seq_stat_t  stat;
  rec_t       rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r <= SPT_A;
    end else if (cfg_we) begin
      spt_r <= cfg_wdata;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  fsi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_track (in_ch.track),
    .in_head  (in_ch.head),
    .spt      (spt_r),
    .out_free (out_free),
    .slot     (slot),
    .stat     (stat)
  );

  fsi_calc u_calc (
    .slot (slot),
    .spt  (spt_r),
    .rec  (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.advance) begin
      out_rec_r <= rec;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.id_track  = out_rec_r.id_track;
  assign out_ch.id_head   = out_rec_r.id_head;
  assign out_ch.sector_id = out_rec_r.sector_id;
  assign out_ch.size_code = out_rec_r.size_code;
  assign out_ch.rejected  = out_rec_r.rejected;
  assign out_ch.last      = out_rec_r.last;

  // Taking an item while one is in flight only happens on its final record.
  `FSI_ASSERT_NOW(a_handoff_on_last, clk, rst_n, stat.accept && stat.busy, stat.advance && slot.last)
  `FSI_ASSERT_NEXT(a_accept_busy, clk, rst_n, stat.accept, stat.busy && (slot.slot == 6'd0))
  `FSI_ASSERT_NOW(a_reject_single, clk, rst_n, out_valid_r && out_rec_r.rejected, out_rec_r.last)
  `FSI_ASSERT_NOW(a_id_range, clk, rst_n, out_valid_r && !out_rec_r.rejected, (out_rec_r.sector_id != 6'd0) && (out_rec_r.sector_id <= spt_r))

endmodule
